// ===== sv/ssdw_pkg.sv =====
// Shared types, constants and the glyph table of the two-wire display writer.
// No dependencies; every other file of the block imports this package.
package ssdw_pkg;

	// Digit positions sent in the data frame, and digit fields on the input item.
	localparam int DIGITS    = 4;
	localparam int IN_DIGITS = 4;

	localparam int BYTE_W     = 8;
	localparam int CODE_W     = 5;
	localparam int HP_W       = 16;
	localparam int BR_W       = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Byte index within a frame must hold the frame length (address byte plus digits).
	localparam int BIDX_W  = $clog2(DIGITS + 2);
	localparam int BCNT_W  = 4;
	localparam int FRAME_W = 2;

	localparam logic [FRAME_W-1:0] FRAME_CMD  = 2'd0;
	localparam logic [FRAME_W-1:0] FRAME_DATA = 2'd1;
	localparam logic [FRAME_W-1:0] FRAME_CTRL = 2'd2;

	localparam logic [BYTE_W-1:0] CMD_DATA  = 8'h40;
	localparam logic [BYTE_W-1:0] CMD_ADDR  = 8'hC0;
	localparam logic [BYTE_W-1:0] CMD_CTRL  = 8'h80;
	localparam logic [BYTE_W-1:0] SEG_BLANK = 8'h00;

	localparam logic [HP_W-1:0] HP_RESET = 16'd100;
	localparam logic [BR_W-1:0] BR_RESET = 3'd1;
	localparam logic            ON_RESET = 1'b1;

	// Item queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_PERIOD = 2'd0,
		CFG_BRIGHTNESS  = 2'd1,
		CFG_DISPLAY_ON  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_REQUEST = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_HI  = 4'd1,
		PH_START_LO  = 4'd2,
		PH_BIT_LOW   = 4'd3,
		PH_BIT_HIGH  = 4'd4,
		PH_ACK_LOW   = 4'd5,
		PH_ACK_HIGH  = 4'd6,
		PH_ACK_END   = 4'd7,
		PH_STOP_LOW  = 4'd8,
		PH_STOP_CLK  = 4'd9,
		PH_STOP_END  = 4'd10
	} phase_t;

	typedef logic [DIGITS-1:0][BYTE_W-1:0] seg_bytes_t;

	typedef struct packed {
		op_t        op;
		seg_bytes_t seg;
	} queue_item_t;

	typedef struct packed {
		logic clock_line;
		logic data_line;
		logic data_drive;
		logic busy;
	} pins_t;

	// Seven-segment pattern of a digit code; codes past the table are blank.
	function automatic logic [BYTE_W-1:0] glyph(input logic [CODE_W-1:0] code);
		logic [BYTE_W-1:0] pat;
		unique case (code)
			5'd0:    pat = 8'h3F;
			5'd1:    pat = 8'h06;
			5'd2:    pat = 8'h5B;
			5'd3:    pat = 8'h4F;
			5'd4:    pat = 8'h66;
			5'd5:    pat = 8'h6D;
			5'd6:    pat = 8'h7D;
			5'd7:    pat = 8'h07;
			5'd8:    pat = 8'h7F;
			5'd9:    pat = 8'h6F;
			5'd10:   pat = 8'h77;
			5'd11:   pat = 8'h7C;
			5'd12:   pat = 8'h58;
			5'd13:   pat = 8'h5E;
			5'd14:   pat = 8'h79;
			5'd15:   pat = 8'h71;
			5'd16:   pat = 8'h76;
			5'd17:   pat = 8'h38;
			5'd18:   pat = 8'h54;
			5'd19:   pat = 8'h73;
			5'd20:   pat = 8'h3E;
			default: pat = SEG_BLANK;
		endcase
		return pat;
	endfunction

endpackage

// ===== sv/ssdw_front.sv =====
// Front end of the display writer: accepts items and turns digit codes into
// segment bytes for the item queue. Depends on ssdw_pkg.
module ssdw_front (
	input  logic                                        in_valid,
	output logic                                        in_stall,
	input  logic                                        operation,
	input  logic [ssdw_pkg::IN_DIGITS-1:0][ssdw_pkg::CODE_W-1:0] digit_codes,
	input  logic [ssdw_pkg::IN_DIGITS-1:0]              dot_flags,
	input  logic                                        q_full,
	output logic                                        push,
	output ssdw_pkg::queue_item_t                       push_item
);
	import ssdw_pkg::*;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_item.op = op_t'(operation);
		for (int k = 0; k < DIGITS; k++) begin
			if (k < IN_DIGITS) begin
				push_item.seg[k] = glyph(digit_codes[k]) | {dot_flags[k], 7'b0};
			end else begin
				push_item.seg[k] = SEG_BLANK;
			end
		end
	end

endmodule

// ===== sv/ssdw_queue.sv =====
// Short first-in first-out queue of classified items between front and back.
// Depends on ssdw_pkg for the item type and depth.
module ssdw_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ssdw_pkg::queue_item_t push_item,
	input  logic                  pop,
	output logic                  full,
	output logic                  head_valid,
	output ssdw_pkg::queue_item_t head_item
);
	import ssdw_pkg::*;

	queue_item_t             entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/ssdw_back.sv =====
// Back end of the display writer: the frame sequencer that drives the pins,
// and the output register for results. Depends on ssdw_pkg.
module ssdw_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  ssdw_pkg::queue_item_t        head_item,
	output logic                         pop,
	input  logic [ssdw_pkg::HP_W-1:0]    half_period,
	input  logic [ssdw_pkg::BR_W-1:0]    brightness,
	input  logic                         display_on,
	output logic                         out_valid,
	input  logic                         out_stall,
	output ssdw_pkg::pins_t              out_pins
);
	import ssdw_pkg::*;

	phase_t               phase_q, phase_d;
	seg_bytes_t           seg_q, seg_d;
	logic [BYTE_W-1:0]    shift_q, shift_d;
	logic [BCNT_W-1:0]    bit_q, bit_d;
	logic [BIDX_W-1:0]    byte_q, byte_d;
	logic [FRAME_W-1:0]   frame_q, frame_d;
	logic [HP_W-1:0]      tick_q, tick_d;
	logic                 out_valid_q;
	pins_t                out_pins_q;
	pins_t                pins_d;

	logic                 step;
	logic                 tick_step;
	logic [HP_W-1:0]      hp_eff;
	logic [HP_W-1:0]      tick_inc;
	logic                 seg_done;
	logic [BIDX_W-1:0]    byte_inc;
	logic [BIDX_W-1:0]    frame_len;
	logic [BIDX_W-1:0]    load_idx;
	logic [BYTE_W-1:0]    load_byte;
	logic [BCNT_W-1:0]    bit_inc;

	// A request never produces a result, so it may leave the queue even while
	// the output register is held.
	assign step      = head_valid && (head_item.op == OP_REQUEST || !out_valid_q || !out_stall);
	assign tick_step = step && (head_item.op == OP_TICK);
	assign pop       = step;

	assign hp_eff    = (half_period == '0) ? HP_W'(1) : half_period;
	assign tick_inc  = tick_q + 1'b1;
	assign seg_done  = (tick_inc >= hp_eff) || (tick_inc == '0);
	assign byte_inc  = byte_q + 1'b1;
	assign bit_inc   = bit_q + 1'b1;
	assign frame_len = (frame_q == FRAME_DATA) ? BIDX_W'(DIGITS + 1) : BIDX_W'(1);
	assign load_idx  = (phase_q == PH_START_LO) ? '0 : byte_inc;

	// Byte to shift out at the given position of the current frame.
	always_comb begin
		load_byte = SEG_BLANK;
		if (frame_q == FRAME_CMD) begin
			load_byte = CMD_DATA;
		end else if (frame_q == FRAME_DATA) begin
			if (load_idx == '0) begin
				load_byte = CMD_ADDR;
			end else begin
				for (int k = 0; k < DIGITS; k++) begin
					if (load_idx == BIDX_W'(k + 1)) begin
						load_byte = seg_q[k];
					end
				end
			end
		end else begin
			load_byte = CMD_CTRL | {4'b0, display_on, brightness};
		end
	end

	// Next state.
	always_comb begin
		phase_d = phase_q;
		seg_d   = seg_q;
		shift_d = shift_q;
		bit_d   = bit_q;
		byte_d  = byte_q;
		frame_d = frame_q;
		tick_d  = tick_q;
		if (step) begin
			if (head_item.op == OP_REQUEST) begin
				if (phase_q == PH_IDLE) begin
					seg_d   = head_item.seg;
					frame_d = '0;
					byte_d  = '0;
					bit_d   = '0;
					tick_d  = '0;
					phase_d = PH_START_HI;
				end
			end else if (phase_q != PH_IDLE) begin
				if (!seg_done) begin
					tick_d = tick_inc;
				end else begin
					tick_d = '0;
					unique case (phase_q)
						PH_START_HI: phase_d = PH_START_LO;
						PH_START_LO: begin
							byte_d  = '0;
							shift_d = load_byte;
							bit_d   = '0;
							phase_d = PH_BIT_LOW;
						end
						PH_BIT_LOW:  phase_d = PH_BIT_HIGH;
						PH_BIT_HIGH: begin
							shift_d = shift_q >> 1;
							bit_d   = bit_inc;
							phase_d = (bit_inc >= BCNT_W'(BYTE_W)) ? PH_ACK_LOW : PH_BIT_LOW;
						end
						PH_ACK_LOW:  phase_d = PH_ACK_HIGH;
						PH_ACK_HIGH: phase_d = PH_ACK_END;
						PH_ACK_END: begin
							byte_d = byte_inc;
							if (byte_inc < frame_len) begin
								shift_d = load_byte;
								bit_d   = '0;
								phase_d = PH_BIT_LOW;
							end else begin
								phase_d = PH_STOP_LOW;
							end
						end
						PH_STOP_LOW: phase_d = PH_STOP_CLK;
						PH_STOP_CLK: phase_d = PH_STOP_END;
						PH_STOP_END: begin
							if (frame_q == FRAME_CTRL) begin
								frame_d = '0;
								phase_d = PH_IDLE;
							end else begin
								frame_d = frame_q + 1'b1;
								phase_d = PH_START_HI;
							end
						end
						PH_IDLE:     phase_d = PH_IDLE;
						default:     phase_d = PH_IDLE;
					endcase
				end
			end
		end
	end

	// Pin levels that follow from the next phase.
	always_comb begin
		pins_d.clock_line = 1'b1;
		pins_d.data_line  = 1'b1;
		pins_d.data_drive = 1'b1;
		pins_d.busy       = (phase_d != PH_IDLE);
		unique case (phase_d)
			PH_START_LO: begin
				pins_d.data_line = 1'b0;
			end
			PH_BIT_LOW: begin
				pins_d.clock_line = 1'b0;
				pins_d.data_line  = shift_d[0];
			end
			PH_BIT_HIGH: begin
				pins_d.data_line = shift_d[0];
			end
			PH_ACK_LOW, PH_ACK_END: begin
				pins_d.clock_line = 1'b0;
				pins_d.data_line  = 1'b0;
				pins_d.data_drive = 1'b0;
			end
			PH_ACK_HIGH: begin
				pins_d.data_line  = 1'b0;
				pins_d.data_drive = 1'b0;
			end
			PH_STOP_LOW: begin
				pins_d.clock_line = 1'b0;
				pins_d.data_line  = 1'b0;
			end
			PH_STOP_CLK: begin
				pins_d.data_line = 1'b0;
			end
			PH_IDLE, PH_START_HI, PH_STOP_END: begin
				pins_d.clock_line = 1'b1;
			end
			default: begin
				pins_d.clock_line = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			seg_q       <= '0;
			shift_q     <= '0;
			bit_q       <= '0;
			byte_q      <= '0;
			frame_q     <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			seg_q   <= seg_d;
			shift_q <= shift_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			frame_q <= frame_d;
			tick_q  <= tick_d;
			if (tick_step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_step) begin
			out_pins_q <= pins_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pins  = out_pins_q;

`ifndef ASSERT_OFF
	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (tick_q == '0 && frame_q == '0))
		else $error("tick or frame count left over while idle");
	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BCNT_W'(BYTE_W))
		else $error("bit count ran past one byte");
	a_byte_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q <= BIDX_W'(DIGITS + 1))
		else $error("byte index ran past the data frame");
	a_result_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head_item.op == OP_REQUEST) |=> !$rose(out_valid_q))
		else $error("a request produced a result");
`endif

endmodule

// ===== sv/seven_segment_two_wire_display_writer.sv =====
// Top level of the two-wire seven-segment display writer.
// A tick item's result passes through the item queue and then the output register of the back.
// Throughput: one item per cycle, set by the single-step frame sequencer; a tick item waits while a result is stalled.
// A request item yields no result and is dropped while an update is running.
// Reset (arst_n low, asynchronous): queue empty, sequencer idle, half_period
// 100, brightness 1, display on; the pin output register is not reset.
module seven_segment_two_wire_display_writer (
	input  logic                              clk,
	input  logic                              arst_n,
	// Item input channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [ssdw_pkg::CODE_W-1:0]       digit_first,
	input  logic [ssdw_pkg::CODE_W-1:0]       digit_second,
	input  logic [ssdw_pkg::CODE_W-1:0]       digit_third,
	input  logic [ssdw_pkg::CODE_W-1:0]       digit_fourth,
	input  logic                              dot_first,
	input  logic                              dot_second,
	input  logic                              dot_third,
	input  logic                              dot_fourth,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              clock_line,
	output logic                              data_line,
	output logic                              data_drive,
	output logic                              busy_res,
	// Configuration write port.
	input  logic                              cfg_write,
	input  logic [ssdw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssdw_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ssdw_pkg::*;

	// Configuration registers. The sequencer reads them directly, so the
	// control byte picks up brightness and display enable when it is loaded.
	logic [HP_W-1:0] half_period_q;
	logic [BR_W-1:0] brightness_q;
	logic            display_on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HP_RESET;
			brightness_q  <= BR_RESET;
			display_on_q  <= ON_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_HALF_PERIOD: half_period_q <= cfg_data[HP_W-1:0];
				CFG_BRIGHTNESS:  brightness_q  <= cfg_data[BR_W-1:0];
				CFG_DISPLAY_ON:  display_on_q  <= cfg_data[0];
				default: begin
					// Writes to unused indexes are dropped.
					half_period_q <= half_period_q;
				end
			endcase
		end
	end

	// The front classifies each item and looks up the segment patterns; the
	// queue lets it keep taking items while the back waits on its output.
	logic [IN_DIGITS-1:0][CODE_W-1:0] digit_codes;
	logic [IN_DIGITS-1:0]             dot_flags;
	logic                             q_full;
	logic                             push;
	queue_item_t                      push_item;
	logic                             pop;
	logic                             head_valid;
	queue_item_t                      head_item;
	pins_t                            out_pins;

	assign digit_codes = {digit_fourth, digit_third, digit_second, digit_first};
	assign dot_flags   = {dot_fourth, dot_third, dot_second, dot_first};

	ssdw_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.digit_codes (digit_codes),
		.dot_flags   (dot_flags),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	ssdw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// The back runs the frame sequencer one item at a time and holds each
	// tick's pin levels in its output register until they are taken.
	ssdw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.half_period (half_period_q),
		.brightness  (brightness_q),
		.display_on  (display_on_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_pins    (out_pins)
	);

	assign clock_line = out_pins.clock_line;
	assign data_line  = out_pins.data_line;
	assign data_drive = out_pins.data_drive;
	assign busy_res   = out_pins.busy;

endmodule
